/* sv/interval_timer_registers_macros.svh */
// ----------------------------------------------------------------------------
// interval_timer_registers_macros.svh
// Assertion helpers for the interval timer RTL.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_TIMER_REGISTERS_MACROS_SVH
`define INTERVAL_TIMER_REGISTERS_MACROS_SVH

// same-cycle implication, disabled during reset
`define ITR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interval timer check failed");

// next-cycle implication, disabled during reset
`define ITR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interval timer check failed");

`endif

/* sv/itr_pkg.sv */
// ----------------------------------------------------------------------------
// itr_pkg
// Types and constants of the interval timer register block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itr_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int HALF_BITS   = 16;
    localparam int HI_BITS     = COUNT_WIDTH - HALF_BITS;
    localparam int IDX_BITS    = 3;
    localparam int FUNC_BITS   = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam int CTRL_ITO_BIT   = 0;
    localparam int CTRL_CONT_BIT  = 1;
    localparam int CTRL_START_BIT = 2;
    localparam int CTRL_STOP_BIT  = 3;

    localparam int STAT_TIMEOUT_BIT = 0;
    localparam int STAT_RUNNING_BIT = 1;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } func_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_STATUS    = 3'd0,
        REG_CONTROL   = 3'd1,
        REG_PERIOD_LO = 3'd2,
        REG_PERIOD_HI = 3'd3,
        REG_SNAP_LO   = 3'd4,
        REG_SNAP_HI   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        func_t                 func;
        reg_idx_t              reg_index;
        logic [HALF_BITS-1:0]  write_data;
    } item_t;

    typedef struct packed {
        logic [HALF_BITS-1:0]  read_data;
        logic                  irq;
    } result_t;

    typedef struct packed {
        logic timeout;
        logic running;
        logic irq_enable;
        logic continuous;
    } status_t;

endpackage

/* sv/itr_core.sv */
// ----------------------------------------------------------------------------
// itr_core
// Timer state and single-pass update for one beat: tick, read or write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itr_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  itr_pkg::item_t  item,
    output itr_pkg::result_t result,
    output itr_pkg::status_t status
);
    import itr_pkg::*;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] period_reg, period_next;
    logic [COUNT_WIDTH-1:0] snap_reg, snap_next;
    logic                   timeout_reg, timeout_next;
    logic                   running_reg, running_next;
    logic                   ien_reg, ien_next;
    logic                   cont_reg, cont_next;
    logic [HALF_BITS-1:0]   read_data;

    always_comb
    begin
        count_next   = count_reg;
        period_next  = period_reg;
        snap_next    = snap_reg;
        timeout_next = timeout_reg;
        running_next = running_reg;
        ien_next     = ien_reg;
        cont_next    = cont_reg;
        read_data    = '0;
        case (item.func)
            FUNC_TICK:
            begin
                if (running_reg)
                begin
                    if (count_reg == '0)
                    begin
                        timeout_next = 1'b1;
                        count_next   = period_reg;
                        if (!cont_reg)
                        begin
                            running_next = 1'b0;
                        end
                    end
                    else
                    begin
                        count_next = count_reg - COUNT_WIDTH'(1);
                    end
                end
            end
            FUNC_READ:
            begin
                case (item.reg_index)
                    REG_STATUS:
                    begin
                        read_data[STAT_TIMEOUT_BIT] = timeout_reg;
                        read_data[STAT_RUNNING_BIT] = running_reg;
                    end
                    REG_CONTROL:
                    begin
                        read_data[CTRL_ITO_BIT]  = ien_reg;
                        read_data[CTRL_CONT_BIT] = cont_reg;
                    end
                    REG_PERIOD_LO: read_data = period_reg[HALF_BITS-1:0];
                    REG_PERIOD_HI: read_data = HALF_BITS'(period_reg[COUNT_WIDTH-1:HALF_BITS]);
                    REG_SNAP_LO:   read_data = snap_reg[HALF_BITS-1:0];
                    REG_SNAP_HI:   read_data = HALF_BITS'(snap_reg[COUNT_WIDTH-1:HALF_BITS]);
                    default:       read_data = '0;
                endcase
            end
            FUNC_WRITE:
            begin
                case (item.reg_index)
                    REG_STATUS:
                    begin
                        timeout_next = 1'b0;
                    end
                    REG_CONTROL:
                    begin
                        ien_next  = item.write_data[CTRL_ITO_BIT];
                        cont_next = item.write_data[CTRL_CONT_BIT];
                        if (item.write_data[CTRL_START_BIT])
                        begin
                            running_next = 1'b1;
                        end
                        if (item.write_data[CTRL_STOP_BIT])
                        begin
                            running_next = 1'b0;
                        end
                    end
                    REG_PERIOD_LO:
                    begin
                        period_next  = {period_reg[COUNT_WIDTH-1:HALF_BITS], item.write_data};
                        count_next   = period_next;
                        running_next = 1'b0;
                    end
                    REG_PERIOD_HI:
                    begin
                        period_next  = {item.write_data[HI_BITS-1:0],
                                        period_reg[HALF_BITS-1:0]};
                        count_next   = period_next;
                        running_next = 1'b0;
                    end
                    REG_SNAP_LO,
                    REG_SNAP_HI:
                    begin
                        snap_next = count_reg;
                    end
                    default:
                    begin
                        snap_next = snap_reg;
                    end
                endcase
            end
            default:
            begin
                read_data = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            period_reg  <= '0;
            snap_reg    <= '0;
            timeout_reg <= 1'b0;
            running_reg <= 1'b0;
            ien_reg     <= 1'b0;
            cont_reg    <= 1'b0;
        end
        else if (fire)
        begin
            count_reg   <= count_next;
            period_reg  <= period_next;
            snap_reg    <= snap_next;
            timeout_reg <= timeout_next;
            running_reg <= running_next;
            ien_reg     <= ien_next;
            cont_reg    <= cont_next;
        end
    end

    assign result.read_data = read_data;
    assign result.irq       = timeout_next & ien_next;

    assign status.timeout    = timeout_reg;
    assign status.running    = running_reg;
    assign status.irq_enable = ien_reg;
    assign status.continuous = cont_reg;

endmodule

/* sv/interval_timer_registers.sv */
// ----------------------------------------------------------------------------
// interval_timer_registers
// 32-bit down-counting interval timer behind six 16-bit registers.
// Registers from input beat to result beat: input register, then result register.
// Throughput: one beat per cycle while m_axis_tready holds; the timer state updates in a single pass.
// Reset: rst_n asynchronous, clears counter, period, snapshot, flags and valids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "interval_timer_registers_macros.svh"

module interval_timer_registers (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [2:0] reg_index, [18:3] write_data, [23:19] zero
    input  logic [itr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] func
    input  logic [itr_pkg::FUNC_BITS-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] read_data, [16] irq, [23:17] zero
    output logic [itr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import itr_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;
    result_t core_result;
    status_t core_status;
    logic    advance;
    logic    in_take;

    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign in_take       = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload until the next beat moves in
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.func       <= func_t'(s_axis_tuser);
            in_item_reg.reg_index  <= reg_idx_t'(s_axis_tdata[IDX_BITS-1:0]);
            in_item_reg.write_data <= s_axis_tdata[IDX_BITS+HALF_BITS-1:IDX_BITS];
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    itr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (core_result),
        .status (core_status)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_result_reg.irq, out_result_reg.read_data});

    `ITR_ASSERT_SAME(a_ready_only_when_full, clk, rst_n, !s_axis_tready, in_valid_reg)
    `ITR_ASSERT_NEXT(a_irq_matches_state, clk, rst_n, advance,
        out_result_reg.irq == (core_status.timeout && core_status.irq_enable))
    `ITR_ASSERT_NEXT(a_no_read_data, clk, rst_n, advance && in_item_reg.func != FUNC_READ,
        out_result_reg.read_data == '0)
    `ITR_ASSERT_NEXT(a_period_write_stops, clk, rst_n,
        advance && in_item_reg.func == FUNC_WRITE &&
        (in_item_reg.reg_index == REG_PERIOD_LO || in_item_reg.reg_index == REG_PERIOD_HI),
        !core_status.running)

endmodule
